// ----- sv/fde_pkg.sv -----
// shared types and constants for the feedback delay echo core
package fde_pkg;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd2;

    // register widths
    localparam int DELAY_W = 18;
    localparam int FB_W    = 15;
    localparam int MIX_W   = 16;

    // register reset values
    localparam int DELAY_RESET = 14400;
    localparam logic [FB_W-1:0]  FB_RESET  = 15'd13107;
    localparam logic [MIX_W-1:0] MIX_RESET = 16'd16384;

    // q0.15 arithmetic
    localparam int Q_SHIFT = 15;
    localparam int Q_HALF  = 16384;
    localparam logic [MIX_W-1:0] Q_UNITY = 16'd32768;

    // per-beat control handed from the issue stage to each lane
    typedef struct packed {
        logic issue;   // a beat enters the lane this cycle
        logic fwd;     // delayed sample is the previous beat's write-back
        logic filled;  // ring entry at the read address has been written
    } lane_ctl_t;

endpackage

// ----- sv/fde_ram.sv -----
// generic simple dual-port ram with registered read
module fde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/fde_lane.sv -----
// one channel lane: ring read, gain products, write-back and dry/wet mix
module fde_lane #(
    parameter int DEPTH        = 262144,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fde_pkg::lane_ctl_t               ctl,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic signed [SAMPLE_WIDTH-1:0]   dry,
    input  logic [fde_pkg::FB_W-1:0]         fb_gain,
    input  logic [fde_pkg::MIX_W-1:0]        dry_gain,
    input  logic [fde_pkg::MIX_W-1:0]        wet_gain,
    output logic                             res_valid,
    output logic signed [SAMPLE_WIDTH-1:0]   res
);
    import fde_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int AW  = $clog2(DEPTH);
    localparam int PFW = SW + FB_W + 1;
    localparam int PMW = SW + MIX_W + 1;
    localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    logic [SW-1:0] ram_q;

    // stage b
    logic                 b_valid_reg;
    logic                 b_fwd_reg;
    logic                 b_filled_reg;
    logic signed [SW-1:0] b_dry_reg;
    logic [AW-1:0]        b_wr_addr_reg;

    // stage c
    logic                  c_valid_reg;
    logic signed [SW-1:0]  c_dry_reg;
    logic [AW-1:0]         c_wr_addr_reg;
    logic signed [PFW-1:0] c_pfb_reg;
    logic signed [PMW-1:0] c_pdry_reg;
    logic signed [PMW-1:0] c_pwet_reg;

    // last write-back value, for a delay of one beat
    logic signed [SW-1:0] hold_reg;

    logic                 out_valid_reg;
    logic signed [SW-1:0] out_reg;

    logic signed [SW-1:0]  wet;
    logic signed [PFW:0]   fb_rnd;
    logic signed [PFW:0]   fb_shift;
    logic signed [SW:0]    fb_val;
    logic signed [SW+1:0]  wsum;
    logic signed [SW-1:0]  wdata;
    logic signed [PMW:0]   msum;
    logic signed [PMW:0]   mshift;
    logic signed [SW+2:0]  mval;
    logic signed [SW-1:0]  mix_sat;

    fde_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (c_valid_reg),
        .waddr (c_wr_addr_reg),
        .wdata (wdata),
        .re    (ctl.issue),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_comb begin
        if (b_fwd_reg) begin
            wet = hold_reg;
        end else if (b_filled_reg) begin
            wet = ram_q;
        end else begin
            wet = '0;
        end
    end

    // feedback write-back: round, add dry, saturate
    always_comb begin
        fb_rnd   = {c_pfb_reg[PFW-1], c_pfb_reg} + (PFW+1)'(Q_HALF);
        fb_shift = fb_rnd >>> Q_SHIFT;
        fb_val   = fb_shift[SW:0];
        wsum     = {{2{c_dry_reg[SW-1]}}, c_dry_reg} + {fb_val[SW], fb_val};
        if (wsum[SW+1:SW-1] == 3'b000 || wsum[SW+1:SW-1] == 3'b111) begin
            wdata = wsum[SW-1:0];
        end else begin
            wdata = wsum[SW+1] ? SMIN : SMAX;
        end
    end

    // dry/wet mix: sum, round, saturate
    always_comb begin
        msum   = {c_pdry_reg[PMW-1], c_pdry_reg} + {c_pwet_reg[PMW-1], c_pwet_reg}
                 + (PMW+1)'(Q_HALF);
        mshift = msum >>> Q_SHIFT;
        mval   = mshift[SW+2:0];
        if (mval[SW+2:SW-1] == 4'b0000 || mval[SW+2:SW-1] == 4'b1111) begin
            mix_sat = mval[SW-1:0];
        end else begin
            mix_sat = mval[SW+2] ? SMIN : SMAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b_valid_reg   <= ctl.issue;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end

        b_fwd_reg     <= ctl.fwd;
        b_filled_reg  <= ctl.filled;
        b_dry_reg     <= dry;
        b_wr_addr_reg <= wr_addr;

        c_dry_reg     <= b_dry_reg;
        c_wr_addr_reg <= b_wr_addr_reg;
        c_pfb_reg     <= PFW'(wet) * PFW'($signed({1'b0, fb_gain}));
        c_pdry_reg    <= PMW'(b_dry_reg) * PMW'($signed({1'b0, dry_gain}));
        c_pwet_reg    <= PMW'(wet) * PMW'($signed({1'b0, wet_gain}));

        if (c_valid_reg) begin
            hold_reg <= wdata;
        end
        out_reg <= mix_sat;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ----- sv/feedback_delay_echo_core.sv -----
// top level of the stereo feedback delay echo core
//
//  port group   dir   beat contents (lsb up)              accepted when
//  s_*          in    sample_left, sample_right           s_tvalid & s_tready
//  m_*          out   out_left, out_right                 m_tvalid & m_tready
//  cfg_*        in    register index, write data          cfg_wr_en
//
//  s_tready is low while the previous beat is in lane stage b; at full rate its ring write-back
//  lands in the same cycle as the next beat's ring read and, for a delay of one, is forwarded
//  from a hold register; a beat passes lane stages b and c and the lane output register before
//  its result is pushed into the output queue; reset needs no ring clearing pass: entries
//  not yet written since reset read as zero; a delay write starts a modulo reduction of the delay
//  below DEPTH, s_tready is low meanwhile; a 4-entry output queue lets beats flow while the result side stalls
module feedback_delay_echo_core #(
    parameter int DEPTH        = 262144,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample_left, sample_right
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_left, out_right
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,
    // configuration writes
    input  logic                                   cfg_wr_en,
    input  logic [fde_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fde_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
    import fde_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int AW  = $clog2(DEPTH);
    localparam int TW  = ((2*SW+7)/8)*8;
    localparam int XW  = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);

    // number of restoring subtract steps to reduce a delay below DEPTH
    function automatic int nstep_calc();
        int n;
        n = 0;
        for (int k = 0; k < 32; k++) begin
            if ((longint'(DEPTH) << k) < (longint'(1) << DELAY_W)) begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    localparam int NSTEP = nstep_calc();
    localparam int CW    = $clog2(NSTEP + 2);
    localparam logic [DELAY_W-1:0] RESET_D = DELAY_W'(DELAY_RESET % DEPTH);

    function automatic logic [DELAY_W-1:0] step_const(input logic [CW-1:0] k);
        return DELAY_W'(longint'(DEPTH) << k);
    endfunction

    // configuration and delay reduction
    logic [DELAY_W-1:0] d_reg;
    logic [CW-1:0]      mod_cnt_reg;
    logic [FB_W-1:0]    fb_reg;
    logic [MIX_W-1:0]   mix_reg;
    logic [DELAY_W-1:0] step_val;

    // ring pointer and issue tracking
    logic [AW-1:0] wr_reg;
    logic          wrapped_reg;
    logic          have_prev_reg;
    logic          acc_last_reg;
    logic [1:0]    inflight_reg;

    // output queue
    logic [2*SW-1:0] q_mem [QD];
    logic [QAW-1:0]  q_wr_reg;
    logic [QAW-1:0]  q_rd_reg;
    logic [QAW:0]    q_cnt_reg;

    logic            accept;
    logic            push;
    logic            pop;
    logic [XW-1:0]   wr_ext;
    logic [XW-1:0]   d_ext;
    logic [XW-1:0]   rd_ext;
    logic [AW-1:0]   rd_addr;
    logic [MIX_W-1:0] wet_gain;
    logic [MIX_W-1:0] dry_gain;
    lane_ctl_t       lane_ctl;
    logic [QAW+1:0]  occupancy;

    logic                 l_valid;
    logic                 r_valid;
    logic signed [SW-1:0] l_res;
    logic signed [SW-1:0] r_res;

    // read address: write pointer minus delay, around the ring
    always_comb begin
        wr_ext = {{(XW-AW){1'b0}}, wr_reg};
        d_ext  = {{(XW-DELAY_W){1'b0}}, d_reg};
        if (wr_ext >= d_ext) begin
            rd_ext = wr_ext - d_ext;
        end else begin
            rd_ext = wr_ext + XW'(DEPTH) - d_ext;
        end
        rd_addr = rd_ext[AW-1:0];
    end

    // mix above unity means wet only
    assign wet_gain = (mix_reg > Q_UNITY) ? Q_UNITY : mix_reg;
    assign dry_gain = Q_UNITY - wet_gain;

    assign step_val = step_const(mod_cnt_reg - CW'(1));

    // room for every beat in flight plus the new one
    assign occupancy = (QAW+2)'(q_cnt_reg) + (QAW+2)'(inflight_reg);
    assign s_tready  = (mod_cnt_reg == '0) && !acc_last_reg && (occupancy < (QAW+2)'(QD));
    assign accept    = s_tvalid && s_tready;

    // entry written iff the ring wrapped or it lies below the write pointer;
    // delay of one reads the beat still being written back
    assign lane_ctl.issue  = accept;
    assign lane_ctl.fwd    = have_prev_reg && (d_reg == DELAY_W'(1));
    assign lane_ctl.filled = wrapped_reg || (rd_addr < wr_reg);

    fde_lane #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SW)
    ) u_lane_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (lane_ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_reg),
        .dry       (s_tdata[SW-1:0]),
        .fb_gain   (fb_reg),
        .dry_gain  (dry_gain),
        .wet_gain  (wet_gain),
        .res_valid (l_valid),
        .res       (l_res)
    );

    fde_lane #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SW)
    ) u_lane_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (lane_ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_reg),
        .dry       (s_tdata[2*SW-1:SW]),
        .fb_gain   (fb_reg),
        .dry_gain  (dry_gain),
        .wet_gain  (wet_gain),
        .res_valid (r_valid),
        .res       (r_res)
    );

    // merge both lanes into one result beat
    assign push = l_valid && r_valid;
    assign pop  = m_tvalid && m_tready;

    // register writes and the delay modulo reduction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg       <= RESET_D;
            fb_reg      <= FB_RESET;
            mix_reg     <= MIX_RESET;
            mod_cnt_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DELAY: begin
                    d_reg       <= cfg_wdata[DELAY_W-1:0];
                    mod_cnt_reg <= CW'(NSTEP);
                end
                REG_FEEDBACK: begin
                    fb_reg <= cfg_wdata[FB_W-1:0];
                end
                REG_MIX: begin
                    mix_reg <= cfg_wdata[MIX_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (mod_cnt_reg != '0) begin
            // one restoring subtract step per cycle while no register write comes in, largest multiple first
            if (d_reg >= step_val) begin
                d_reg <= d_reg - step_val;
            end
            mod_cnt_reg <= mod_cnt_reg - CW'(1);
        end
    end

    // write pointer, fill tracking and beats in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg        <= '0;
            wrapped_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            acc_last_reg  <= 1'b0;
            inflight_reg  <= '0;
        end else begin
            acc_last_reg <= accept;
            if (accept) begin
                have_prev_reg <= 1'b1;
                if (wr_reg == AW'(DEPTH - 1)) begin
                    wr_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wr_reg <= wr_reg + AW'(1);
                end
            end
            case ({accept, push})
                2'b10:   inflight_reg <= inflight_reg + 2'd1;
                2'b01:   inflight_reg <= inflight_reg - 2'd1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    // output queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            if (push) begin
                q_wr_reg <= q_wr_reg + QAW'(1);
            end
            if (pop) begin
                q_rd_reg <= q_rd_reg + QAW'(1);
            end
            case ({push, pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + (QAW+1)'(1);
                2'b01:   q_cnt_reg <= q_cnt_reg - (QAW+1)'(1);
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
        if (push) begin
            q_mem[q_wr_reg] <= {r_res, l_res};
        end
    end

    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = TW'(q_mem[q_rd_reg]);

endmodule
